/* sv/atcs_pkg.sv */
// ----------------------------------------------------------------------------
// atcs_pkg
// Shared types and constants of the ANSI text console sequencer.
// ----------------------------------------------------------------------------
package atcs_pkg;

	localparam int unsigned DEF_COLUMNS     = 256;
	localparam int unsigned DEF_ROWS        = 128;
	localparam int unsigned DEF_DIGIT_LIMIT = 3;

	localparam int unsigned RGB_W       = 24;
	localparam int unsigned PAL_ENTRIES = 8;
	localparam int unsigned PAL_AW      = $clog2(PAL_ENTRIES);
	localparam int unsigned APB_AW      = PAL_AW + 2;
	localparam int unsigned APB_DW      = 32;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned TAB_STEP    = 4;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SGR    = 8'h6D;
	localparam logic [7:0] CH_SEP    = 8'h3B;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [5:0] SGR_FG_FIRST = 6'd30;
	localparam logic [5:0] SGR_FG_LAST  = 6'd37;

	localparam logic [RGB_W-1:0] DEFAULT_FORE = 24'h839496;
	localparam logic [RGB_W-1:0] DEFAULT_BACK = 24'h002B36;

	typedef enum logic [2:0] {
		OP_NEWLINE,
		OP_TAB,
		OP_ESC,
		OP_LBRACKET,
		OP_SGR_END,
		OP_SEP,
		OP_DIGIT,
		OP_OTHER
	} op_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_ESC,
		MODE_CSI
	} mode_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] code;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qslot_t;

endpackage

/* sv/atcs_ram.sv */
// ----------------------------------------------------------------------------
// atcs_ram
// Generic RAM: one write port, two registered read ports, write-first.
// ----------------------------------------------------------------------------
module atcs_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= (we && waddr == raddr_a) ? wdata : mem_q[raddr_a];
		rdata_b_q <= (we && waddr == raddr_b) ? wdata : mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

/* sv/atcs_front.sv */
// ----------------------------------------------------------------------------
// atcs_front
// Input side: takes character requests and tags each with its command class.
// ----------------------------------------------------------------------------
module atcs_front (
	input  logic             char_valid,
	output logic             char_stall,
	input  logic [7:0]       char_code,
	output atcs_pkg::qslot_t push,
	input  logic             full
);
	import atcs_pkg::*;

	op_t op;

	always_comb begin
		case (char_code)
			CH_NL:     op = OP_NEWLINE;
			CH_TAB:    op = OP_TAB;
			CH_ESC:    op = OP_ESC;
			CH_LBRACK: op = OP_LBRACKET;
			CH_SGR:    op = OP_SGR_END;
			CH_SEP:    op = OP_SEP;
			default: begin
				if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
					op = OP_DIGIT;
				end else begin
					op = OP_OTHER;
				end
			end
		endcase
	end

	assign push.valid    = char_valid;
	assign push.cmd.op   = op;
	assign push.cmd.code = char_code;
	assign char_stall    = full;

endmodule

/* sv/atcs_queue.sv */
// ----------------------------------------------------------------------------
// atcs_queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module atcs_queue #(
	parameter int unsigned DEPTH = atcs_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  atcs_pkg::qslot_t push,
	output logic             full,
	output atcs_pkg::qslot_t head,
	input  logic             pop
);
	import atcs_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push.valid && !full;

	assign head.valid = (count_q != '0);
	assign head.cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/atcs_back.sv */
// ----------------------------------------------------------------------------
// atcs_back
// Execution side: escape parser, SGR parameter, cursor, colors and the
// registered draw request.
// ----------------------------------------------------------------------------
module atcs_back #(
	parameter int unsigned COLUMNS     = atcs_pkg::DEF_COLUMNS,
	parameter int unsigned ROWS        = atcs_pkg::DEF_ROWS,
	parameter int unsigned DIGIT_LIMIT = atcs_pkg::DEF_DIGIT_LIMIT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  atcs_pkg::qslot_t             head,
	output logic                         pop,
	output logic [atcs_pkg::PAL_AW-1:0]  pal_addr,
	input  logic [atcs_pkg::RGB_W-1:0]   pal_rgb,
	output logic                         glyph_valid,
	input  logic                         glyph_stall,
	output logic [7:0]                   glyph_code,
	output logic [7:0]                   cell_column,
	output logic [6:0]                   cell_row,
	output logic [atcs_pkg::RGB_W-1:0]   fore_rgb,
	output logic [atcs_pkg::RGB_W-1:0]   back_rgb
);
	import atcs_pkg::*;

	localparam int unsigned COL_W   = $clog2(COLUMNS);
	localparam int unsigned ROW_W   = $clog2(ROWS);
	localparam int unsigned PARAM_W = $clog2(10 ** DIGIT_LIMIT);
	localparam int unsigned CH_W    = $clog2(DIGIT_LIMIT + 1);
	localparam int unsigned EXT_W   = (PARAM_W > 6) ? PARAM_W : 6;

	localparam logic [COL_W:0]   COL_MAX_X = (COL_W + 1)'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_MAX   = ROW_W'(ROWS - 1);

	mode_t              mode_q, mode_d;
	logic [PARAM_W-1:0] param_q, param_d;
	logic [CH_W-1:0]    chars_q, chars_d;
	logic               stopped_q, stopped_d;
	logic [COL_W-1:0]   col_q, col_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic [RGB_W-1:0]   fore_q, fore_d;
	logic [RGB_W-1:0]   back_q, back_d;

	logic               out_valid_q;
	logic [7:0]         glyph_code_q;
	logic [7:0]         cell_column_q;
	logic [6:0]         cell_row_q;
	logic [RGB_W-1:0]   fore_rgb_q;
	logic [RGB_W-1:0]   back_rgb_q;

	op_t                op;
	logic               is_draw;
	logic               out_free;
	logic [COL_W:0]     col_sum;
	logic [COL_W-1:0]   col_sat;
	logic [PARAM_W+3:0] param_x10;
	logic [EXT_W-1:0]   param_ext;
	logic [COL_W+7:0]   col_ext;
	logic [ROW_W+6:0]   row_ext;

	assign op       = head.cmd.op;
	assign out_free = !out_valid_q || !glyph_stall;

	always_comb begin
		case (op)
			OP_NEWLINE, OP_TAB, OP_ESC: is_draw = 1'b0;
			default: begin
				if (mode_q == MODE_CSI) begin
					is_draw = 1'b0;
				end else if (mode_q == MODE_ESC && op == OP_LBRACKET) begin
					is_draw = 1'b0;
				end else begin
					is_draw = 1'b1;
				end
			end
		endcase
	end

	assign pop = head.valid && (!is_draw || out_free);

	// saturating column advance, by one for a draw and by a tab step
	assign col_sum = {1'b0, col_q} + ((op == OP_TAB) ? (COL_W + 1)'(TAB_STEP) : (COL_W + 1)'(1));
	assign col_sat = (col_sum > COL_MAX_X) ? COL_MAX_X[COL_W-1:0] : col_sum[COL_W-1:0];

	assign param_x10 = ((PARAM_W + 4)'(param_q) << 3) + ((PARAM_W + 4)'(param_q) << 1)
		+ (PARAM_W + 4)'(head.cmd.code[3:0]);
	assign param_ext = EXT_W'(param_q);

	always_comb begin
		mode_d    = mode_q;
		param_d   = param_q;
		chars_d   = chars_q;
		stopped_d = stopped_q;
		col_d     = col_q;
		row_d     = row_q;
		fore_d    = fore_q;
		back_d    = back_q;
		if (pop) begin
			case (op)
				OP_NEWLINE: begin
					row_d = (row_q == ROW_MAX) ? row_q : row_q + 1'b1;
					col_d = COL_W'(1);
				end
				OP_TAB: begin
					col_d = col_sat;
				end
				OP_ESC: begin
					mode_d = MODE_ESC;
				end
				default: begin
					if (mode_q == MODE_CSI) begin
						if (op == OP_SGR_END || op == OP_SEP) begin
							if (param_q == '0) begin
								fore_d = DEFAULT_FORE;
								back_d = DEFAULT_BACK;
							end else if (param_ext >= EXT_W'(SGR_FG_FIRST)
									&& param_ext <= EXT_W'(SGR_FG_LAST)) begin
								fore_d = pal_rgb;
							end
							param_d   = '0;
							chars_d   = '0;
							stopped_d = 1'b0;
							if (op == OP_SGR_END) begin
								mode_d = MODE_IDLE;
							end
						end else if (chars_q < CH_W'(DIGIT_LIMIT)) begin
							chars_d = chars_q + 1'b1;
							if (!stopped_q) begin
								if (op == OP_DIGIT) begin
									param_d = param_x10[PARAM_W-1:0];
								end else begin
									stopped_d = 1'b1;
								end
							end
						end
					end else if (mode_q == MODE_ESC && op == OP_LBRACKET) begin
						param_d   = '0;
						chars_d   = '0;
						stopped_d = 1'b0;
						mode_d    = MODE_CSI;
					end else begin
						mode_d = MODE_IDLE;
						col_d  = col_sat;
					end
				end
			endcase
		end
	end

	// palette read follows the parameter register, so the data lines up with param_q
	assign pal_addr = param_d[PAL_AW-1:0] - SGR_FG_FIRST[PAL_AW-1:0];

	assign col_ext = (COL_W + 8)'(col_q);
	assign row_ext = (ROW_W + 7)'(row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			param_q     <= '0;
			chars_q     <= '0;
			stopped_q   <= 1'b0;
			col_q       <= COL_W'(1);
			row_q       <= '0;
			fore_q      <= DEFAULT_FORE;
			back_q      <= DEFAULT_BACK;
			out_valid_q <= 1'b0;
		end else begin
			mode_q    <= mode_d;
			param_q   <= param_d;
			chars_q   <= chars_d;
			stopped_q <= stopped_d;
			col_q     <= col_d;
			row_q     <= row_d;
			fore_q    <= fore_d;
			back_q    <= back_d;
			if (pop && is_draw) begin
				out_valid_q <= 1'b1;
			end else if (!glyph_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_draw) begin
			glyph_code_q  <= head.cmd.code;
			cell_column_q <= col_ext[7:0];
			cell_row_q    <= row_ext[6:0];
			fore_rgb_q    <= fore_q;
			back_rgb_q    <= back_q;
		end
	end

	assign glyph_valid = out_valid_q;
	assign glyph_code  = glyph_code_q;
	assign cell_column = cell_column_q;
	assign cell_row    = cell_row_q;
	assign fore_rgb    = fore_rgb_q;
	assign back_rgb    = back_rgb_q;

endmodule

/* sv/ansi_text_console_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// ansi_text_console_sequencer_unit
// Text console front end: parses ANSI SGR color sequences and cursor control
// characters and issues one draw request per character outside those.
// ----------------------------------------------------------------------------
//   channel | dir | handshake                  | payload
//   char    | in  | char_valid / char_stall    | char_code
//   glyph   | out | glyph_valid / glyph_stall  | glyph_code, cell_column, cell_row,
//           |     |                            | fore_rgb, back_rgb
//   cfg     | in  | APB psel/penable/pready    | palette_0..7 at 4*i
//
// One character per cycle sustained while glyph_stall stays low. The front
// classifies each character into the queue on the accepting edge; the back then
// executes it into the output register, which raises the draw request. The back
// updates parser and cursor once per entry. A draw blocked at the output holds
// the next draw; the two-entry queue absorbs input until it fills, then char_stall
// rises. Reset is asynchronous and leaves the palette reading as zero until written.
// ----------------------------------------------------------------------------
module ansi_text_console_sequencer_unit #(
	parameter int unsigned COLUMNS     = atcs_pkg::DEF_COLUMNS,
	parameter int unsigned ROWS        = atcs_pkg::DEF_ROWS,
	parameter int unsigned DIGIT_LIMIT = atcs_pkg::DEF_DIGIT_LIMIT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [atcs_pkg::APB_AW-1:0] paddr,
	input  logic [atcs_pkg::APB_DW-1:0] pwdata,
	output logic [atcs_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        char_valid,
	output logic                        char_stall,
	input  logic [7:0]                  char_code,
	output logic                        glyph_valid,
	input  logic                        glyph_stall,
	output logic [7:0]                  glyph_code,
	output logic [7:0]                  cell_column,
	output logic [6:0]                  cell_row,
	output logic [atcs_pkg::RGB_W-1:0]  fore_rgb,
	output logic [atcs_pkg::RGB_W-1:0]  back_rgb
);
	import atcs_pkg::*;

	qslot_t              push;
	qslot_t              head;
	logic                full;
	logic                pop;
	logic                cfg_we;
	logic [PAL_AW-1:0]   cfg_addr;
	logic [PAL_AW-1:0]   pal_addr;
	logic [RGB_W-1:0]    rd_a;
	logic [RGB_W-1:0]    rd_b;
	logic [PAL_ENTRIES-1:0] pal_valid_q;
	logic                hit_a_q;
	logic                hit_b_q;
	logic [RGB_W-1:0]    pal_rgb;

	assign pready   = 1'b1;
	assign cfg_we   = psel && penable && pwrite && pready;
	assign cfg_addr = paddr[PAL_AW+1:2];

	// entry valid bits stand in for the palette's reset to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
		end else if (cfg_we) begin
			pal_valid_q[cfg_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		hit_a_q <= pal_valid_q[pal_addr] || (cfg_we && cfg_addr == pal_addr);
		hit_b_q <= pal_valid_q[cfg_addr] || cfg_we;
	end

	atcs_ram #(
		.WIDTH (RGB_W),
		.DEPTH (PAL_ENTRIES)
	) u_pal (
		.clk     (clk),
		.we      (cfg_we),
		.waddr   (cfg_addr),
		.wdata   (pwdata[RGB_W-1:0]),
		.raddr_a (pal_addr),
		.rdata_a (rd_a),
		.raddr_b (cfg_addr),
		.rdata_b (rd_b)
	);

	assign pal_rgb = hit_a_q ? rd_a : '0;
	assign prdata  = {{(APB_DW - RGB_W){1'b0}}, (hit_b_q ? rd_b : {RGB_W{1'b0}})};

	atcs_front u_front (
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.push       (push),
		.full       (full)
	);

	atcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.head   (head),
		.pop    (pop)
	);

	atcs_back #(
		.COLUMNS     (COLUMNS),
		.ROWS        (ROWS),
		.DIGIT_LIMIT (DIGIT_LIMIT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.pal_addr    (pal_addr),
		.pal_rgb     (pal_rgb),
		.glyph_valid (glyph_valid),
		.glyph_stall (glyph_stall),
		.glyph_code  (glyph_code),
		.cell_column (cell_column),
		.cell_row    (cell_row),
		.fore_rgb    (fore_rgb),
		.back_rgb    (back_rgb)
	);

endmodule

/* sv/atcs_checker.sv */
// ----------------------------------------------------------------------------
// atcs_checker
// Port-level checks of the console sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module atcs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       char_valid,
	input logic                       char_stall,
	input logic                       glyph_valid,
	input logic                       glyph_stall,
	input logic [7:0]                 glyph_code,
	input logic [7:0]                 cell_column,
	input logic [6:0]                 cell_row,
	input logic [atcs_pkg::RGB_W-1:0] fore_rgb,
	input logic [atcs_pkg::RGB_W-1:0] back_rgb
);

	// a stalled draw request holds
	a_glyph_hold: assert property (@(posedge clk) disable iff (!arst_n)
		glyph_valid && glyph_stall |=> glyph_valid && $stable(glyph_code)
			&& $stable(cell_column) && $stable(cell_row)
			&& $stable(fore_rgb) && $stable(back_rgb))
		else $error("glyph request changed while stalled");

	// the queue only fills behind a blocked draw
	a_stall_needs_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> glyph_valid)
		else $error("input stalled with no pending draw request");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(char_stall) |-> $past(glyph_valid && glyph_stall))
		else $error("input stall rose without output back-pressure");

endmodule

bind ansi_text_console_sequencer_unit atcs_checker u_atcs_checker (.*);

/* dv/console_draw_checker.sv */
// ----------------------------------------------------------------------------
// console_draw_checker
// Watches the character, draw and palette ports of the text console sequencer.
// It keeps its own copy of the parser, cursor and colors, predicts each draw
// request and compares the draw requests that leave the block, field by field.
// ----------------------------------------------------------------------------
module console_draw_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [atcs_pkg::APB_AW-1:0] paddr,
	input  logic [atcs_pkg::APB_DW-1:0] pwdata,
	input  logic                        char_valid,
	input  logic                        char_stall,
	input  logic [7:0]                  char_code,
	input  logic                        glyph_valid,
	input  logic                        glyph_stall,
	input  logic [7:0]                  glyph_code,
	input  logic [7:0]                  cell_column,
	input  logic [6:0]                  cell_row,
	input  logic [atcs_pkg::RGB_W-1:0]  fore_rgb,
	input  logic [atcs_pkg::RGB_W-1:0]  back_rgb,
	input  logic                        end_of_test,
	output int                          error_count,
	output int                          pending_draws
);
	timeunit 1ns;
	timeprecision 1ps;

	import atcs_pkg::*;

	localparam int unsigned PRINT_LIMIT = 50;

	typedef struct packed {
		logic [7:0]       glyph;
		logic [7:0]       column;
		logic [6:0]       row;
		logic [RGB_W-1:0] fore;
		logic [RGB_W-1:0] back;
	} draw_t;

	draw_t            expected_draws[$];
	logic [RGB_W-1:0] palette_copy[PAL_ENTRIES];
	mode_t            parser_mode;
	int unsigned      sgr_value;
	int unsigned      sgr_chars;
	bit               sgr_stopped;
	int unsigned      cursor_col;
	int unsigned      cursor_row;
	logic [RGB_W-1:0] cur_fore;
	logic [RGB_W-1:0] cur_back;
	bit               leftovers_checked = 1'b0;

	initial begin
		error_count   = 0;
		pending_draws = 0;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("draw %s: got %0h, expected %0h", name, got, want));
	endtask

	task automatic reset_console();
		for (int i = 0; i < PAL_ENTRIES; i++)
			palette_copy[i] = '0;
		expected_draws.delete();
		parser_mode = MODE_IDLE;
		sgr_value   = 0;
		sgr_chars   = 0;
		sgr_stopped = 1'b0;
		cursor_col  = 1;
		cursor_row  = 0;
		cur_fore    = DEFAULT_FORE;
		cur_back    = DEFAULT_BACK;
	endtask

	task automatic clear_sgr();
		sgr_value   = 0;
		sgr_chars   = 0;
		sgr_stopped = 1'b0;
	endtask

	task automatic apply_sgr();
		if (sgr_value == 0) begin
			cur_fore = DEFAULT_FORE;
			cur_back = DEFAULT_BACK;
		end else if (sgr_value >= SGR_FG_FIRST && sgr_value <= SGR_FG_LAST) begin
			cur_fore = palette_copy[sgr_value - SGR_FG_FIRST];
		end
		clear_sgr();
	endtask

	// only the first DIGIT_LIMIT characters count; a non-digit freezes the value
	task automatic take_sgr_char(input logic [7:0] c);
		if (sgr_chars >= DEF_DIGIT_LIMIT)
			return;
		sgr_chars++;
		if (sgr_stopped)
			return;
		if (c >= CH_ZERO && c <= CH_NINE)
			sgr_value = sgr_value * 10 + (c - CH_ZERO);
		else
			sgr_stopped = 1'b1;
	endtask

	task automatic advance_cursor(input int unsigned by);
		cursor_col = (cursor_col + by > DEF_COLUMNS - 1) ? DEF_COLUMNS - 1 : cursor_col + by;
	endtask

	task automatic predict_char(input logic [7:0] c);
		draw_t d;
		if (c == CH_NL) begin
			if (cursor_row < DEF_ROWS - 1)
				cursor_row++;
			cursor_col = 1;
		end else if (c == CH_TAB) begin
			advance_cursor(TAB_STEP);
		end else if (c == CH_ESC) begin
			parser_mode = MODE_ESC;
		end else if (parser_mode == MODE_CSI) begin
			if (c == CH_SGR) begin
				apply_sgr();
				parser_mode = MODE_IDLE;
			end else if (c == CH_SEP) begin
				apply_sgr();
			end else begin
				take_sgr_char(c);
			end
		end else if (parser_mode == MODE_ESC && c == CH_LBRACK) begin
			clear_sgr();
			parser_mode = MODE_CSI;
		end else begin
			// plain character, or the byte after a lone ESC
			parser_mode = MODE_IDLE;
			d.glyph  = c;
			d.column = cursor_col[7:0];
			d.row    = cursor_row[6:0];
			d.fore   = cur_fore;
			d.back   = cur_back;
			expected_draws.push_back(d);
			advance_cursor(1);
		end
	endtask

	task automatic compare_draw();
		draw_t want;
		if (expected_draws.size() == 0) begin
			report_mismatch($sformatf("unexpected draw request, glyph %0h", glyph_code));
			return;
		end
		want = expected_draws.pop_front();
		check_field("glyph_code", glyph_code, want.glyph);
		check_field("cell_column", cell_column, want.column);
		check_field("cell_row", cell_row, want.row);
		check_field("fore_rgb", fore_rgb, want.fore);
		check_field("back_rgb", back_rgb, want.back);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_console();
		end else begin
			if (psel && penable && pwrite && pready)
				palette_copy[paddr[APB_AW-1:2]] = pwdata[RGB_W-1:0];
			if (char_valid && !char_stall)
				predict_char(char_code);
			if (glyph_valid && !glyph_stall)
				compare_draw();
			if (end_of_test && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (expected_draws.size() != 0)
					report_mismatch($sformatf("%0d draw requests never came out",
						expected_draws.size()));
			end
		end
		pending_draws = expected_draws.size();
	end

endmodule

/* dv/ansi_text_console_sequencer_unit_tb.sv */
// ----------------------------------------------------------------------------
// ansi_text_console_sequencer_unit_tb
// Drives character bytes and palette writes into the console sequencer with
// random gaps and output stalls; a checker beside the block predicts the draw
// requests and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module ansi_text_console_sequencer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import atcs_pkg::*;

	localparam int unsigned PALETTE_BASE     = 0;	// register index of palette_0
	localparam int unsigned RANDOM_PHASES    = 6;
	localparam int unsigned CHARS_PER_PHASE  = 270;
	localparam int unsigned LONG_HOLD_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES    = 8;
	localparam int unsigned DRAIN_LIMIT      = 20000;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              char_valid;
	logic              char_stall;
	logic [7:0]        char_code;
	logic              glyph_valid;
	logic              glyph_stall;
	logic [7:0]        glyph_code;
	logic [7:0]        cell_column;
	logic [6:0]        cell_row;
	logic [RGB_W-1:0]  fore_rgb;
	logic [RGB_W-1:0]  back_rgb;
	logic              end_of_test;
	int                mismatch_count;
	int                pending_draws;
	int unsigned       chars_sent;
	bit                hold_request;
	bit                quiet_input;
	bit                quiet_output;

	ansi_text_console_sequencer_unit u_top (.*);

	console_draw_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.char_code     (char_code),
		.glyph_valid   (glyph_valid),
		.glyph_stall   (glyph_stall),
		.glyph_code    (glyph_code),
		.cell_column   (cell_column),
		.cell_row      (cell_row),
		.fore_rgb      (fore_rgb),
		.back_rgb      (back_rgb),
		.end_of_test   (end_of_test),
		.error_count   (mismatch_count),
		.pending_draws (pending_draws)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// draw request back-pressure: mostly short stalls, some long, and a
	// counted long hold-off when the stimulus asks for one
	initial begin
		int unsigned roll;
		glyph_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				glyph_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
			end else if (quiet_output || !arst_n) begin
				glyph_stall <= 1'b0;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 70) begin
					glyph_stall <= 1'b0;
				end else begin
					glyph_stall <= 1'b1;
					if (roll < 95)
						repeat ($urandom_range(0, 3)) @(negedge clk);
					else if (roll < 99)
						repeat ($urandom_range(4, 14)) @(negedge clk);
					else
						repeat ($urandom_range(19, 39)) @(negedge clk);
				end
			end
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (quiet_input)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// any byte the parser does not treat as cursor or escape control
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_NL || b == CH_TAB || b == CH_ESC);
		return b;
	endfunction

	function automatic logic [7:0] sgr_junk();
		logic [7:0] b;
		do
			b = plain_byte();
		while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEP || b == CH_SGR);
		return b;
	endfunction

	function automatic logic [7:0] digit(input int unsigned hi);
		return 8'(CH_ZERO + $urandom_range(0, hi));
	endfunction

	task automatic send_char(input logic [7:0] c);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_valid <= 1'b1;
		char_code  <= c;
		forever begin
			@(posedge clk);
			if (!char_stall)
				break;
		end
		chars_sent++;
	endtask

	task automatic apb_write(input int unsigned index, input logic [RGB_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(index * 4);
		pwdata  <= APB_DW'(value);
		@(negedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready)
				break;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// stop sending, let every draw request out, then let control bytes settle
	task automatic wait_idle();
		int unsigned waited;
		waited = 0;
		@(negedge clk);
		char_valid <= 1'b0;
		while (pending_draws != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_palette(input int unsigned phase);
		logic [RGB_W-1:0] value;
		for (int i = 0; i < PAL_ENTRIES; i++) begin
			if (phase == 0)
				value = '1;
			else if (phase == 1)
				value = '0;
			else if ($urandom_range(0, 3) == 0)
				value = $urandom_range(0, 1) ? '1 : '0;
			else
				value = RGB_W'($urandom());
			apb_write(PALETTE_BASE + i, value);
		end
	endtask

	// ESC [ params m, mostly well formed, sometimes cut short or corrupted
	task automatic send_sgr();
		logic [7:0]  text[$];
		int unsigned params;
		int unsigned kind;
		send_char(CH_ESC);
		send_char(CH_LBRACK);
		params = $urandom_range(1, 3);
		for (int p = 0; p < params; p++) begin
			text.delete();
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				text.push_back(CH_ZERO + 8'd3);
				text.push_back(digit(7));
			end else if (kind < 60) begin
				if ($urandom_range(0, 1))
					text.push_back(CH_ZERO);
			end else if (kind < 75) begin
				repeat ($urandom_range(1, 4)) text.push_back(digit(9));
			end else if (kind < 88) begin
				repeat ($urandom_range(0, 2)) text.push_back(digit(9));
				text.push_back(sgr_junk());
				repeat ($urandom_range(0, 2)) text.push_back(digit(9));
			end else begin
				// one leading zero still fits the digit limit; two push the code past it
				repeat ($urandom_range(1, 2)) text.push_back(CH_ZERO);
				text.push_back(CH_ZERO + 8'd3);
				text.push_back(digit(7));
			end
			foreach (text[k])
				send_char(text[k]);
			if (p < params - 1)
				send_char(CH_SEP);
		end
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			send_char(CH_SGR);
		end else if (kind < 92) begin
			send_char($urandom_range(0, 1) ? CH_NL : CH_TAB);
			send_char(CH_SGR);
		end else if (kind < 96) begin
			send_char(CH_ESC);
		end
	endtask

	task automatic send_random_chunk();
		int unsigned roll;
		logic [7:0]  b;
		roll = $urandom_range(0, 99);
		if (roll < 35) begin
			repeat ($urandom_range(1, 8)) send_char(plain_byte());
		end else if (roll < 60) begin
			send_sgr();
		end else if (roll < 70) begin
			send_char(CH_NL);
		end else if (roll < 78) begin
			send_char(CH_TAB);
		end else if (roll < 84) begin
			do
				b = plain_byte();
			while (b == CH_LBRACK);
			send_char(CH_ESC);
			send_char(b);
		end else if (roll < 96) begin
			send_char(8'($urandom_range(0, 255)));
		end else if (roll < 98) begin
			// run the cursor into the right edge
			repeat ($urandom_range(60, 70)) send_char(CH_TAB);
			send_char(plain_byte());
		end else begin
			repeat ($urandom_range(20, 40)) send_char(CH_NL);
		end
	endtask

	initial begin
		logic [7:0]  opening[];
		int unsigned target;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		char_valid   = 1'b0;
		char_code    = '0;
		end_of_test  = 1'b0;
		chars_sent   = 0;
		hold_request = 1'b0;
		quiet_input  = 1'b0;
		quiet_output = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// palette still at reset: byte extremes, lone ESC, color codes,
		// newline inside a sequence, stopped number, ESC inside a sequence
		opening = '{8'h00, 8'hFF, CH_TAB, CH_ESC, "q",
			CH_ESC, CH_LBRACK, "3", "1", CH_SGR, "a",
			CH_ESC, CH_LBRACK, "3", CH_NL, "7", CH_SEP, "x", CH_SGR, "b",
			CH_ESC, CH_LBRACK, CH_ESC, CH_SEP, "c"};
		foreach (opening[i])
			send_char(opening[i]);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			load_palette(phase);
			quiet_input  = (phase == 3);
			quiet_output = (phase == 3) || (phase == 4);
			if (phase == 2 || phase == 5)
				hold_request = 1'b1;
			target = chars_sent + CHARS_PER_PHASE;
			while (chars_sent < target)
				send_random_chunk();
		end
		wait_idle();

		@(negedge clk);
		end_of_test <= 1'b1;
		repeat (2) @(negedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* sim.f */
sv/atcs_pkg.sv
sv/atcs_ram.sv
sv/atcs_front.sv
sv/atcs_queue.sv
sv/atcs_back.sv
sv/ansi_text_console_sequencer_unit.sv
sv/atcs_checker.sv
dv/console_draw_checker.sv
dv/ansi_text_console_sequencer_unit_tb.sv
